@@ src/vector3_fixed_point_alu_top_assert.svh @@
// Assertion macros for the vector ALU top-level source.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef VECTOR3_FIXED_POINT_ALU_TOP_ASSERT_SVH
`define VECTOR3_FIXED_POINT_ALU_TOP_ASSERT_SVH

// Same-cycle implication.
`define VFA_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vector ALU assertion failed");

// Next-cycle implication.
`define VFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vector ALU assertion failed");

`endif

@@ src/vfa_pkg.sv @@
package vfa_pkg;

  // Default word geometry: signed Q16.16 in 32 bits.
  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  // One lane per vector component.
  localparam int NUM_LANES = 3;

  // Operation codes.
  typedef enum logic [2:0] {
    FUNC_ADD       = 3'd0,
    FUNC_SUB       = 3'd1,
    FUNC_SCALE     = 3'd2,
    FUNC_DOT       = 3'd3,
    FUNC_LENGTH    = 3'd4,
    FUNC_NORMALIZE = 3'd5,
    FUNC_LERP      = 3'd6
  } func_e;

  // Pipeline control handed to the iterative units.
  typedef struct packed {
    logic valid;
    logic en;
  } pipe_ctrl_t;

endpackage

@@ src/vfa_in_if.sv @@
interface vfa_in_if #(
  parameter int WORD_BITS = vfa_pkg::WORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [2:0]                  func;
  logic signed [WORD_BITS-1:0] a_x;
  logic signed [WORD_BITS-1:0] a_y;
  logic signed [WORD_BITS-1:0] a_z;
  logic signed [WORD_BITS-1:0] b_x;
  logic signed [WORD_BITS-1:0] b_y;
  logic signed [WORD_BITS-1:0] b_z;
  logic signed [WORD_BITS-1:0] factor;

  modport source (
    output valid, func, a_x, a_y, a_z, b_x, b_y, b_z, factor,
    input  ready
  );

  modport sink (
    input  valid, func, a_x, a_y, a_z, b_x, b_y, b_z, factor,
    output ready
  );
endinterface

@@ src/vfa_out_if.sv @@
interface vfa_out_if #(
  parameter int WORD_BITS = vfa_pkg::WORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] r_x;
  logic signed [WORD_BITS-1:0] r_y;
  logic signed [WORD_BITS-1:0] r_z;
  logic signed [WORD_BITS-1:0] r_scalar;
  logic                        overflow;

  modport source (
    output valid, r_x, r_y, r_z, r_scalar, overflow,
    input  ready
  );

  modport sink (
    input  valid, r_x, r_y, r_z, r_scalar, overflow,
    output ready
  );
endinterface

@@ src/vfa_lane.sv @@
module vfa_lane #(
  parameter int WORD_BITS = vfa_pkg::WORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  vfa_pkg::func_e              func_i,
  input  logic signed [WORD_BITS-1:0] a_i,
  input  logic signed [WORD_BITS-1:0] b_i,
  input  logic signed [WORD_BITS-1:0] k_i,
  output logic signed [2*WORD_BITS:0] prod_o,
  output logic signed [WORD_BITS:0]   sum_o,
  output logic signed [WORD_BITS-1:0] a_o
);
  import vfa_pkg::*;

  localparam int W = WORD_BITS;

  logic signed [W:0]   a_ext, b_ext, k_ext;
  logic signed [W:0]   x_d, x_q;
  logic signed [W-1:0] y_d, y_q;
  logic signed [W:0]   sum_d, sum1_q, sum2_q;
  logic signed [W-1:0] a1_q, a2_q;
  logic signed [2*W:0] prod_q;

  // Operand selection for the lane multiplier and the adder.
  always_comb begin
    a_ext = {a_i[W-1], a_i};
    b_ext = {b_i[W-1], b_i};
    k_ext = {k_i[W-1], k_i};
    x_d   = '0;
    y_d   = '0;
    sum_d = '0;
    unique case (func_i)
      FUNC_ADD: begin
        sum_d = a_ext + b_ext;
      end
      FUNC_SUB: begin
        sum_d = a_ext - b_ext;
      end
      FUNC_SCALE: begin
        x_d = k_ext;
        y_d = a_i;
      end
      FUNC_DOT: begin
        x_d = a_ext;
        y_d = b_i;
      end
      FUNC_LENGTH, FUNC_NORMALIZE: begin
        x_d = a_ext;
        y_d = a_i;
      end
      FUNC_LERP: begin
        x_d = b_ext - a_ext;
        y_d = k_i;
      end
      default: begin
      end
    endcase
  end

  // Operand register, then the product register.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      sum1_q <= sum_d;
      a1_q   <= a_i;
      prod_q <= x_q * y_q;
      sum2_q <= sum1_q;
      a2_q   <= a1_q;
    end
  end

  assign prod_o = prod_q;
  assign sum_o  = sum2_q;
  assign a_o    = a2_q;

endmodule

@@ src/vfa_sqrt.sv @@
module vfa_sqrt #(
  parameter int WORD_BITS = vfa_pkg::WORD_BITS_DEF,
  parameter int TAG_W     = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  vfa_pkg::pipe_ctrl_t      ctrl_i,
  input  logic [2*WORD_BITS-1:0]   rad_i,
  input  logic [TAG_W-1:0]         tag_i,
  output logic                     valid_o,
  output logic [WORD_BITS-1:0]     root_o,
  output logic [TAG_W-1:0]         tag_o
);
  import vfa_pkg::*;

  localparam int W = WORD_BITS;

  logic [2*W-1:0]   x_s    [0:W];
  logic [W-1:0]     rem_s  [0:W];
  logic [W-1:0]     root_s [0:W];
  logic [TAG_W-1:0] tag_s  [0:W];
  logic             vld_s  [0:W];

  assign x_s[0]    = rad_i;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign tag_s[0]  = tag_i;
  assign vld_s[0]  = ctrl_i.valid;

  // One root bit per stage, two radicand bits consumed per stage.
  for (genvar i = 0; i < W; i++) begin : g_stage
    logic [W+1:0]     rem_sh, trial, diff;
    logic             ge;
    logic [2*W-1:0]   x_q;
    logic [W-1:0]     rem_q, root_q;
    logic [TAG_W-1:0] tag_q;
    logic             vld_q;

    always_comb begin
      rem_sh = {rem_s[i], x_s[i][2*W-1 -: 2]};
      trial  = {root_s[i], 2'b01};
      diff   = rem_sh - trial;
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.en) begin
        x_q    <= {x_s[i][2*W-3:0], 2'b00};
        rem_q  <= ge ? diff[W-1:0] : rem_sh[W-1:0];
        root_q <= {root_s[i][W-2:0], ge};
        tag_q  <= tag_s[i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (ctrl_i.en) begin
        vld_q <= vld_s[i];
      end
    end

    assign x_s[i+1]    = x_q;
    assign rem_s[i+1]  = rem_q;
    assign root_s[i+1] = root_q;
    assign tag_s[i+1]  = tag_q;
    assign vld_s[i+1]  = vld_q;
  end

  assign valid_o = vld_s[W];
  assign root_o  = root_s[W];
  assign tag_o   = tag_s[W];

endmodule

@@ src/vfa_div.sv @@
module vfa_div #(
  parameter int WORD_BITS = vfa_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = vfa_pkg::FRAC_BITS_DEF,
  parameter int TAG_W     = 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  vfa_pkg::pipe_ctrl_t            ctrl_i,
  input  logic [WORD_BITS+FRAC_BITS-1:0] num_i [vfa_pkg::NUM_LANES],
  input  logic [WORD_BITS-1:0]           den_i,
  input  logic [TAG_W-1:0]               tag_i,
  output logic                           valid_o,
  output logic [WORD_BITS+FRAC_BITS-1:0] quo_o [vfa_pkg::NUM_LANES],
  output logic [TAG_W-1:0]               tag_o
);
  import vfa_pkg::*;

  localparam int W = WORD_BITS;
  localparam int N = WORD_BITS + FRAC_BITS;

  logic [N-1:0]     num_s [0:N][NUM_LANES];
  logic [N-1:0]     quo_s [0:N][NUM_LANES];
  logic [W-1:0]     rem_s [0:N][NUM_LANES];
  logic [W-1:0]     den_s [0:N];
  logic [TAG_W-1:0] tag_s [0:N];
  logic             vld_s [0:N];

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_in
    assign num_s[0][l] = num_i[l];
    assign quo_s[0][l] = '0;
    assign rem_s[0][l] = '0;
  end
  assign den_s[0] = den_i;
  assign tag_s[0] = tag_i;
  assign vld_s[0] = ctrl_i.valid;

  // Restoring division, one quotient bit per stage in each lane.
  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [W-1:0]     den_q;
    logic [TAG_W-1:0] tag_q;
    logic             vld_q;

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      logic [W:0]   rem_sh, diff;
      logic         ge;
      logic [N-1:0] num_q, quo_q;
      logic [W-1:0] rem_q;

      always_comb begin
        rem_sh = {rem_s[i][l], num_s[i][l][N-1]};
        diff   = rem_sh - {1'b0, den_s[i]};
        ge     = (rem_sh >= {1'b0, den_s[i]});
      end

      always_ff @(posedge clk_i) begin
        if (ctrl_i.en) begin
          num_q <= {num_s[i][l][N-2:0], 1'b0};
          quo_q <= {quo_s[i][l][N-2:0], ge};
          rem_q <= ge ? diff[W-1:0] : rem_sh[W-1:0];
        end
      end

      assign num_s[i+1][l] = num_q;
      assign quo_s[i+1][l] = quo_q;
      assign rem_s[i+1][l] = rem_q;
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.en) begin
        den_q <= den_s[i];
        tag_q <= tag_s[i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (ctrl_i.en) begin
        vld_q <= vld_s[i];
      end
    end

    assign den_s[i+1] = den_q;
    assign tag_s[i+1] = tag_q;
    assign vld_s[i+1] = vld_q;
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_out
    assign quo_o[l] = quo_s[N][l];
  end
  assign valid_o = vld_s[N];
  assign tag_o   = tag_s[N];

endmodule

@@ src/vector3_fixed_point_alu_top.sv @@
// Three-component signed fixed-point vector ALU.
// Requests arrive on req_i (valid/ready); each carries an operation code,
// vectors a and b and a scalar factor. Results leave on rsp_o (valid/ready)
// with the result vector, a scalar result and an overflow flag.
// Three multiplier lanes, one per component, feed a merging stage that
// forms sums, truncating shifts and saturation. Length and normalize use a
// pipelined square root (WORD_BITS stages) and a pipelined three-lane
// divider (WORD_BITS + FRAC_BITS stages); every operation takes the same
// path, so results return in request order.
// Pipeline depth is set by the root and divider stage counts (Q16.16 by default).
// Throughput is one request per cycle while the pipeline is not stalled.
// The whole pipeline advances whenever the output register is empty or
// being taken, so a stalled receiver holds every stage and drops ready.
// Reset empties all stages and the output register; payload registers
// keep their contents.
module vector3_fixed_point_alu_top #(
  parameter int WORD_BITS = vfa_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = vfa_pkg::FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  vfa_in_if.sink           req_i,
  vfa_out_if.source        rsp_o
);
  import vfa_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int NL  = NUM_LANES;
  localparam int SW  = (2 * W + 3 > W + F + 2) ? 2 * W + 3 : W + F + 2;
  localparam int T1W = 7 * W + 4;
  localparam int T2W = T1W + 1;
  localparam logic [SW-1:0] FRAC_MASK = {{(SW - F){1'b0}}, {F{1'b1}}};
  localparam logic [W-1:0]  SAT_MAX   = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0]  SAT_MIN   = {1'b1, {(W - 1){1'b0}}};

  // Saturate to the word range; the top bit flags saturation.
  function automatic logic [W:0] sat_fn(input logic signed [SW-1:0] v);
    logic hi_ones, hi_zeros;
    hi_ones  = &v[SW-1:W-1];
    hi_zeros = ~|v[SW-1:W-1];
    if (hi_ones || hi_zeros) begin
      return {1'b0, v[W-1:0]};
    end else if (v[SW-1]) begin
      return {1'b1, SAT_MIN};
    end
    return {1'b1, SAT_MAX};
  endfunction

  // Arithmetic shift right by the fraction width, rounding toward zero.
  function automatic logic signed [SW-1:0] trunc_fn(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] bias;
    bias = v[SW-1] ? FRAC_MASK : '0;
    return (v + bias) >>> F;
  endfunction

  logic en;
  logic out_valid_q;

  assign en          = !out_valid_q || rsp_o.ready;
  assign req_i.ready = en;

  // Front stages: lanes hold operand and product registers.
  logic v1_q, v2_q;
  func_e func_in, func1_q, func2_q;
  logic signed [W-1:0]   in_a [NL];
  logic signed [W-1:0]   in_b [NL];
  logic signed [2*W:0]   prod [NL];
  logic signed [W:0]     sum  [NL];
  logic signed [W-1:0]   la   [NL];

  assign func_in = func_e'(req_i.func);
  assign in_a[0] = req_i.a_x;
  assign in_a[1] = req_i.a_y;
  assign in_a[2] = req_i.a_z;
  assign in_b[0] = req_i.b_x;
  assign in_b[1] = req_i.b_y;
  assign in_b[2] = req_i.b_z;

  for (genvar l = 0; l < NL; l++) begin : g_lane
    vfa_lane #(
      .WORD_BITS(W)
    ) u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .func_i(func_in),
      .a_i   (in_a[l]),
      .b_i   (in_b[l]),
      .k_i   (req_i.factor),
      .prod_o(prod[l]),
      .sum_o (sum[l]),
      .a_o   (la[l])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      func1_q <= func_in;
      func2_q <= func1_q;
    end
  end

  // Merging stage: combine lane results.
  logic                   v3_q;
  func_e                  m_func_q;
  logic [NL-1:0][W-1:0]   m_a_q, m_r_d, m_r_q;
  logic [W-1:0]           m_s_d, m_s_q;
  logic                   m_ovf_d, m_ovf_q;
  logic [2*W-1:0]         m_sq_d, m_sq_q;

  always_comb begin
    logic [W:0]           sv;
    logic signed [SW-1:0] acc;
    m_r_d   = '0;
    m_s_d   = '0;
    m_ovf_d = 1'b0;
    m_sq_d  = '0;
    sv      = '0;
    acc     = SW'(prod[0]) + SW'(prod[1]) + SW'(prod[2]);
    unique case (func2_q)
      FUNC_ADD, FUNC_SUB: begin
        for (int l = 0; l < NL; l++) begin
          sv       = sat_fn(SW'(sum[l]));
          m_r_d[l] = sv[W-1:0];
          m_ovf_d  = m_ovf_d | sv[W];
        end
      end
      FUNC_SCALE: begin
        for (int l = 0; l < NL; l++) begin
          sv       = sat_fn(trunc_fn(SW'(prod[l])));
          m_r_d[l] = sv[W-1:0];
          m_ovf_d  = m_ovf_d | sv[W];
        end
      end
      FUNC_LERP: begin
        for (int l = 0; l < NL; l++) begin
          sv       = sat_fn(SW'(la[l]) + trunc_fn(SW'(prod[l])));
          m_r_d[l] = sv[W-1:0];
          m_ovf_d  = m_ovf_d | sv[W];
        end
      end
      FUNC_DOT: begin
        sv      = sat_fn(trunc_fn(acc));
        m_s_d   = sv[W-1:0];
        m_ovf_d = sv[W];
      end
      FUNC_LENGTH, FUNC_NORMALIZE: begin
        m_sq_d = acc[2*W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_func_q <= func2_q;
      for (int l = 0; l < NL; l++) begin
        m_a_q[l] <= la[l];
      end
      m_r_q   <= m_r_d;
      m_s_q   <= m_s_d;
      m_ovf_q <= m_ovf_d;
      m_sq_q  <= m_sq_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= req_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Square root of the sum of squares.
  pipe_ctrl_t           sq_ctrl;
  logic                 sq_valid;
  logic [W-1:0]         root;
  logic [T1W-1:0]       sq_tag_in, sq_tag;
  logic [2:0]           sq_func;
  logic [NL-1:0][W-1:0] sq_a, sq_r;
  logic [W-1:0]         sq_s;
  logic                 sq_ovf;

  assign sq_ctrl   = '{valid: v3_q, en: en};
  assign sq_tag_in = {m_func_q, m_a_q, m_r_q, m_s_q, m_ovf_q};

  vfa_sqrt #(
    .WORD_BITS(W),
    .TAG_W    (T1W)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (sq_ctrl),
    .rad_i  (m_sq_q),
    .tag_i  (sq_tag_in),
    .valid_o(sq_valid),
    .root_o (root),
    .tag_o  (sq_tag)
  );

  assign {sq_func, sq_a, sq_r, sq_s, sq_ovf} = sq_tag;

  // Length result and divider operands.
  pipe_ctrl_t     dv_ctrl;
  logic [W+F-1:0] num [NL];
  logic [W+F-1:0] quo [NL];
  logic [W-1:0]   ds_s;
  logic           ds_ovf, len_zero, dv_valid;
  logic [T2W-1:0] dv_tag_in, dv_tag;

  always_comb begin
    len_zero = (root == '0);
    ds_s     = sq_s;
    ds_ovf   = sq_ovf;
    if (sq_func == FUNC_LENGTH) begin
      ds_s   = root[W-1] ? SAT_MAX : root;
      ds_ovf = root[W-1];
    end
  end

  for (genvar l = 0; l < NL; l++) begin : g_num
    logic [W-1:0] mag;
    assign mag    = sq_a[l][W-1] ? (~sq_a[l] + 1'b1) : sq_a[l];
    assign num[l] = {mag, {F{1'b0}}};
  end

  assign dv_ctrl   = '{valid: sq_valid, en: en};
  assign dv_tag_in = {sq_func, sq_a, sq_r, ds_s, ds_ovf, len_zero};

  vfa_div #(
    .WORD_BITS(W),
    .FRAC_BITS(F),
    .TAG_W    (T2W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (dv_ctrl),
    .num_i  (num),
    .den_i  (root),
    .tag_i  (dv_tag_in),
    .valid_o(dv_valid),
    .quo_o  (quo),
    .tag_o  (dv_tag)
  );

  // Normalize result and the output register.
  logic [2:0]           dv_func;
  logic [NL-1:0][W-1:0] dv_a, dv_r;
  logic [W-1:0]         dv_s;
  logic                 dv_ovf, dv_lz;
  logic [NL-1:0][W-1:0] out_r_d, out_r_q;
  logic [W-1:0]         out_s_q;
  logic                 out_ovf_d, out_ovf_q;

  assign {dv_func, dv_a, dv_r, dv_s, dv_ovf, dv_lz} = dv_tag;

  always_comb begin
    logic signed [SW-1:0] qv;
    logic [W:0]           sv;
    out_r_d   = dv_r;
    out_ovf_d = dv_ovf;
    qv        = '0;
    sv        = '0;
    if (dv_func == FUNC_NORMALIZE) begin
      if (dv_lz) begin
        out_r_d = dv_a;
      end else begin
        for (int l = 0; l < NL; l++) begin
          qv         = SW'(quo[l]);
          sv         = sat_fn(dv_a[l][W-1] ? -qv : qv);
          out_r_d[l] = sv[W-1:0];
          out_ovf_d  = out_ovf_d | sv[W];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && dv_valid) begin
      out_r_q   <= out_r_d;
      out_s_q   <= dv_s;
      out_ovf_q <= out_ovf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.r_x      = $signed(out_r_q[0]);
  assign rsp_o.r_y      = $signed(out_r_q[1]);
  assign rsp_o.r_z      = $signed(out_r_q[2]);
  assign rsp_o.r_scalar = $signed(out_s_q);
  assign rsp_o.overflow = out_ovf_q;

  // Some field of the held result sits at a saturation limit.
  logic rsp_sat_any;

  assign rsp_sat_any = (out_r_q[0] == SAT_MAX) || (out_r_q[0] == SAT_MIN) ||
                       (out_r_q[1] == SAT_MAX) || (out_r_q[1] == SAT_MIN) ||
                       (out_r_q[2] == SAT_MAX) || (out_r_q[2] == SAT_MIN) ||
                       (out_s_q == SAT_MAX) || (out_s_q == SAT_MIN);

  `include "vector3_fixed_point_alu_top_assert.svh"

  // A held result stalls the whole pipeline, input included.
  `VFA_ASSERT(a_stall_blocks_req, rsp_o.valid && !rsp_o.ready, !req_i.ready)
  // An empty output register never refuses a request.
  `VFA_ASSERT(a_empty_takes_req, !rsp_o.valid, req_i.ready)
  // An accepted request occupies the first stage on the next cycle.
  `VFA_ASSERT_NEXT(a_req_enters_pipe, req_i.valid && req_i.ready, v1_q)
  // The overflow flag only comes with a saturated field.
  `VFA_ASSERT(a_ovf_means_sat, rsp_o.valid && rsp_o.overflow, rsp_sat_any)

endmodule

@@ verif/tb_vfa_if.sv @@
`timescale 1ns / 1ps

// Testbench-side request and response channels are the RTL interfaces
// vfa_in_if and vfa_out_if; this file holds the shared request and response records.
package tb_vfa_pkg;

  // One request as the stimulus side builds it.
  typedef struct {
    logic [2:0]         func;
    logic signed [31:0] a_x, a_y, a_z;
    logic signed [31:0] b_x, b_y, b_z;
    logic signed [31:0] factor;
  } vec_req_t;

  // One response as the predictor forms it.
  typedef struct {
    logic signed [31:0] r_x, r_y, r_z, r_scalar;
    logic               overflow;
  } vec_rsp_t;

endpackage

@@ verif/tb_vector3_fixed_point_alu_top.sv @@
`timescale 1ns / 1ps

module tb_vector3_fixed_point_alu_top;
  import vfa_pkg::*;
  import tb_vfa_pkg::*;

  localparam int LATENCY = 84;
  localparam int CYCLE_LIMIT = 400000;

  logic clk_i;
  logic rst_ni;
  int   cycle_cnt;
  int   err_cnt;
  int   rsp_cnt;
  int   req_cnt;
  int   func_cnt [8];
  int   sat_cnt;
  bit   no_idle;

  vfa_in_if  req_if ();
  vfa_out_if rsp_if ();

  vec_rsp_t expected_q [$];

  vector3_fixed_point_alu_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Clock generation.
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Cycle counter and watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("[vector3_fixed_point_alu_top] ERROR");
      $finish;
    end
  end

  // Saturate a wide signed value to 32 bits and flag overflow.
  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
                                                 inout logic ovf);
    if (v > 128'sd2147483647) begin
      ovf = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -128'sd2147483648) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Arithmetic shift right by the fraction bits, truncating toward zero.
  function automatic logic signed [127:0] drop_frac(input logic signed [127:0] v);
    logic signed [127:0] m;
    m = (v < 0) ? -v : v;
    m = m >>> 16;
    return (v < 0) ? -m : m;
  endfunction

  // Floor square root of a nonnegative wide value.
  function automatic logic [127:0] floor_root(input logic [127:0] v);
    logic [127:0] res, cand;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = res | (128'd1 << b);
      if (cand * cand <= v) res = cand;
    end
    return res;
  endfunction

  // Compute the response that one request must produce.
  function automatic vec_rsp_t predict_vector_op(input vec_req_t rq);
    vec_rsp_t rs;
    logic signed [127:0] a [3], b [3], k, acc, q;
    logic [127:0] len, m;
    logic ovf;
    ovf = 1'b0;
    a[0] = rq.a_x; a[1] = rq.a_y; a[2] = rq.a_z;
    b[0] = rq.b_x; b[1] = rq.b_y; b[2] = rq.b_z;
    k = rq.factor;
    rs = '{default: '0};
    case (rq.func)
      FUNC_ADD: begin
        rs.r_x = clamp32(a[0] + b[0], ovf);
        rs.r_y = clamp32(a[1] + b[1], ovf);
        rs.r_z = clamp32(a[2] + b[2], ovf);
      end
      FUNC_SUB: begin
        rs.r_x = clamp32(a[0] - b[0], ovf);
        rs.r_y = clamp32(a[1] - b[1], ovf);
        rs.r_z = clamp32(a[2] - b[2], ovf);
      end
      FUNC_SCALE: begin
        rs.r_x = clamp32(drop_frac(k * a[0]), ovf);
        rs.r_y = clamp32(drop_frac(k * a[1]), ovf);
        rs.r_z = clamp32(drop_frac(k * a[2]), ovf);
      end
      FUNC_DOT: begin
        acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        rs.r_scalar = clamp32(drop_frac(acc), ovf);
      end
      FUNC_LENGTH, FUNC_NORMALIZE: begin
        acc = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        len = floor_root(acc);
        if (rq.func == FUNC_LENGTH) begin
          rs.r_scalar = clamp32(len, ovf);
        end else if (len == 0) begin
          // A zero-length vector passes through unchanged.
          rs.r_x = rq.a_x;
          rs.r_y = rq.a_y;
          rs.r_z = rq.a_z;
        end else begin
          logic signed [31:0] r [3];
          for (int i = 0; i < 3; i++) begin
            m = (a[i] < 0) ? -a[i] : a[i];
            q = (m << 16) / len;
            r[i] = clamp32((a[i] < 0) ? -q : q, ovf);
          end
          rs.r_x = r[0]; rs.r_y = r[1]; rs.r_z = r[2];
        end
      end
      FUNC_LERP: begin
        rs.r_x = clamp32(a[0] + drop_frac(k * (b[0] - a[0])), ovf);
        rs.r_y = clamp32(a[1] + drop_frac(k * (b[1] - a[1])), ovf);
        rs.r_z = clamp32(a[2] + drop_frac(k * (b[2] - a[2])), ovf);
      end
      default: ;
    endcase
    rs.overflow = ovf;
    return rs;
  endfunction

  // Print one mismatch and count it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d on response %0d: %s got %h want %h",
             cycle_cnt, rsp_cnt, what, got, want);
    err_cnt++;
  endtask

  // Response side: random stall, and check each accepted response.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        vec_rsp_t w;
        if (expected_q.size() == 0) begin
          $display("unexpected response at cycle %0d", cycle_cnt);
          err_cnt++;
        end else begin
          w = expected_q.pop_front();
          if (rsp_if.r_x !== w.r_x) report_mismatch("r_x", rsp_if.r_x, w.r_x);
          if (rsp_if.r_y !== w.r_y) report_mismatch("r_y", rsp_if.r_y, w.r_y);
          if (rsp_if.r_z !== w.r_z) report_mismatch("r_z", rsp_if.r_z, w.r_z);
          if (rsp_if.r_scalar !== w.r_scalar) begin
            report_mismatch("r_scalar", rsp_if.r_scalar, w.r_scalar);
          end
          if (rsp_if.overflow !== w.overflow) begin
            report_mismatch("overflow", rsp_if.overflow, w.overflow);
          end
        end
        rsp_cnt++;
      end
      rsp_if.ready <= no_idle || ($urandom_range(99) >= 32);
    end
  end

  // Send one request, with a random idle gap before it.
  task automatic send_request(input vec_req_t rq);
    while (!no_idle && $urandom_range(99) < 32) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid  <= 1'b1;
    req_if.func   <= rq.func;
    req_if.a_x    <= rq.a_x;
    req_if.a_y    <= rq.a_y;
    req_if.a_z    <= rq.a_z;
    req_if.b_x    <= rq.b_x;
    req_if.b_y    <= rq.b_y;
    req_if.b_z    <= rq.b_z;
    req_if.factor <= rq.factor;
    do @(posedge clk_i); while (!req_if.ready);
    expected_q.push_back(predict_vector_op(rq));
    if (expected_q[$].overflow) sat_cnt++;
    func_cnt[rq.func]++;
    req_cnt++;
  endtask

  // Random component: mostly moderate values, sometimes full range or extremes.
  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      1, 2:    return $urandom();
      3:       return $signed($urandom_range(65535)) - 32768;
      default: return $signed($urandom_range(32'h01ffffff)) - 32'sh01000000;
    endcase
  endfunction

  function automatic vec_req_t rand_request(input logic [2:0] f);
    vec_req_t rq;
    rq.func = f;
    rq.a_x = rand_word(); rq.a_y = rand_word(); rq.a_z = rand_word();
    rq.b_x = rand_word(); rq.b_y = rand_word(); rq.b_z = rand_word();
    rq.factor = ($urandom_range(3) == 0) ? rand_word()
                : $signed($urandom_range(32'h00020000)) - 32'sh00010000;
    return rq;
  endfunction

  // Stop sending and wait until every expected response has been checked.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Extremes, zero-length normalize and the unused operation code.
  task automatic test_directed();
    vec_req_t rq;
    logic signed [31:0] ext [4];
    ext = '{32'sh7fffffff, 32'sh80000000, 32'sh0, 32'sh00010000};
    for (int f = 0; f < 8; f++) begin
      rq = '{func: f[2:0], a_x: ext[0], a_y: ext[1], a_z: ext[3],
             b_x: ext[1], b_y: ext[0], b_z: ext[2], factor: ext[f % 2]};
      send_request(rq);
    end
    // Zero vector for length and normalize.
    rq = '{func: FUNC_NORMALIZE, a_x: 0, a_y: 0, a_z: 0,
           b_x: -1, b_y: -1, b_z: -1, factor: -1};
    send_request(rq);
    rq.func = FUNC_LENGTH;
    send_request(rq);
    // Zero vector again, then a tiny vector whose length rounds down to one LSB.
    rq = '{func: FUNC_NORMALIZE, a_x: 0, a_y: 0, a_z: 0,
           b_x: 0, b_y: 0, b_z: 0, factor: 0};
    rq.a_x = 0; rq.a_y = 0; rq.a_z = 0;
    send_request(rq);
    rq.a_x = 1; rq.a_y = -1; rq.a_z = 0;
    send_request(rq);
    // All bits high for every used operation code.
    for (int f = 0; f < 7; f++) begin
      rq = '{func: f[2:0], a_x: -1, a_y: -1, a_z: -1,
             b_x: -1, b_y: -1, b_z: -1, factor: -1};
      send_request(rq);
    end
  endtask

  // Random operations, including the unused code now and then.
  task automatic test_random(input int count);
    for (int n = 0; n < count; n++) begin
      send_request(rand_request(($urandom_range(19) == 0) ? 3'd7
                                : 3'($urandom_range(6))));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cycle_cnt = 0;
    err_cnt = 0;
    rsp_cnt = 0;
    req_cnt = 0;
    sat_cnt = 0;
    no_idle = 1'b0;
    foreach (func_cnt[i]) func_cnt[i] = 0;
    req_if.valid = 1'b0;
    req_if.func = '0;
    req_if.a_x = '0; req_if.a_y = '0; req_if.a_z = '0;
    req_if.b_x = '0; req_if.b_y = '0; req_if.b_z = '0;
    req_if.factor = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(500);
    // Hold off the sender until the pipeline has drained completely.
    wait_drained();
    no_idle = 1'b1;
    test_random(300);
    no_idle = 1'b0;
    test_random(525);

    wait_drained();
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("sent %0d requests, checked %0d responses, %0d saturating",
             req_cnt, rsp_cnt, sat_cnt);
    $display("per operation: %0d %0d %0d %0d %0d %0d %0d unused %0d",
             func_cnt[0], func_cnt[1], func_cnt[2], func_cnt[3],
             func_cnt[4], func_cnt[5], func_cnt[6], func_cnt[7]);
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("[vector3_fixed_point_alu_top] OK");
    end else begin
      $display("[vector3_fixed_point_alu_top] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/vfa_pkg.sv
src/vfa_in_if.sv
src/vfa_out_if.sv
src/vfa_lane.sv
src/vfa_sqrt.sv
src/vfa_div.sv
src/vector3_fixed_point_alu_top.sv
verif/tb_vfa_if.sv
verif/tb_vector3_fixed_point_alu_top.sv
